// ===== hdl/fhm_pkg.sv =====
// Shared types and codes for the FIFO hand-off mutex.
`timescale 1ns / 1ps
package fhm_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  // Outcome codes reported with every result item.
  localparam logic [2:0] OC_GRANTED  = 3'd0;
  localparam logic [2:0] OC_WAIT     = 3'd1;
  localparam logic [2:0] OC_FREED    = 3'd2;
  localparam logic [2:0] OC_HANDOVER = 3'd3;
  localparam logic [2:0] OC_IGNORED  = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] proc_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic       queue_full;
    logic [7:0] woken_id;
    logic [7:0] holder_id;
    logic       is_locked;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read the entry behind the head
    logic commit;   // apply the request and load the result register
  } ctl_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctl_state_t;

endpackage

// ===== hdl/fhm_ctrl.sv =====
// Controller state machine of the FIFO hand-off mutex.
`timescale 1ns / 1ps
module fhm_ctrl
  import fhm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_ready,
  output logic     in_ready,
  output logic     out_valid,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only loaded when the previous one has been taken or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");
  // Every captured item is followed by its commit before another capture.
  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC) && !cmd.capture)
    else $error("capture not followed by execute state");
  // The result register becomes valid exactly after a commit.
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without a commit");
`endif

endmodule

// ===== hdl/fhm_datapath.sv =====
// Datapath of the FIFO hand-off mutex: wait queue, pointers, owner and result register.
`timescale 1ns / 1ps
module fhm_datapath
  import fhm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [ID_BITS-1:0] queue_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  logic               req_r;
  logic [ID_BITS-1:0] pid_r;

  logic               held_r, held_nxt;
  logic [ID_BITS-1:0] owner_r, owner_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [PTR_W-1:0]   head_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail_idx;
  logic               queue_is_full;
  logic               do_write;

  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign queue_is_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_write = cmd.commit && (req_r == REQ_LOCK) && !queue_is_full;

  always_comb begin
    held_nxt     = held_r;
    owner_nxt    = owner_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    out_item_nxt = out_item_r;
    if (cmd.commit) begin
      out_item_nxt.outcome    = OC_IGNORED;
      out_item_nxt.queue_full = 1'b0;
      out_item_nxt.woken_id   = '0;
      if (req_r == REQ_LOCK) begin
        if (queue_is_full) begin
          out_item_nxt.queue_full = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          if (held_r) begin
            out_item_nxt.outcome = OC_WAIT;
          end else begin
            owner_nxt            = pid_r;
            held_nxt             = 1'b1;
            out_item_nxt.outcome = OC_GRANTED;
          end
        end
      end else if (held_r) begin
        // The owner sits at the head; popping it exposes the next waiter.
        if (count_r != '0) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
        if (count_nxt != '0) begin
          owner_nxt             = rd_data_r;
          out_item_nxt.woken_id = 8'(rd_data_r);
          out_item_nxt.outcome  = OC_HANDOVER;
        end else begin
          held_nxt             = 1'b0;
          owner_nxt            = '0;
          out_item_nxt.outcome = OC_FREED;
        end
      end
      out_item_nxt.holder_id = 8'(owner_nxt);
      out_item_nxt.is_locked = held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      queue_mem[tail_idx] <= pid_r;
    end
    if (cmd.capture) begin
      rd_data_r <= queue_mem[head_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item.req_type;
      pid_r <= ID_BITS'(in_item.proc_id);
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      owner_r <= '0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      held_r  <= held_nxt;
      owner_r <= owner_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_item = out_item_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");
  // The owner is always the queue head, so held and non-empty go together.
  a_held_iff_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == (count_r != '0))
    else $error("lock state disagrees with queue occupancy");
  a_free_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (owner_r == '0))
    else $error("free lock still has an owner");
`endif

endmodule

// ===== hdl/fifo_handoff_mutex_top.sv =====
// Top level of the FIFO hand-off mutex: controller plus datapath.
// The result item of an accepted request is loaded into the result register by the
// commit in the execute state, which follows capture. A new request is taken only
// once the previous one is committed. The queue read behind the head is registered,
// so each item passes capture, then execute. A held result stalls only execute.
// Reset (rst_n low, synchronous) frees the lock and empties the queue at once.
`timescale 1ns / 1ps
module fifo_handoff_mutex_top
  import fhm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // The controller only sequences: it decides when an item is captured and
  // when it is applied, and it owns the valid flag of the result register.
  ctl_cmd_t cmd;

  fhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the wait queue (a circular buffer with head pointer and
  // entry count), the lock flag, the owner id and the result register. The
  // owner is always the entry at the head of the queue, so a handover simply
  // reads the entry behind the head, fetched during the capture cycle.
  fhm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ===== tb/fhm_checker.sv =====
// Checker for the FIFO hand-off mutex: predicts each result item and compares it.
`timescale 1ns / 1ps
module fhm_checker
  import fhm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        outstanding
);

  localparam int SLOTS = 16;

  // Shadow copy of the lock and its wait queue.
  logic       held;
  logic [7:0] owner;
  logic [7:0] slots [SLOTS];
  logic [3:0] head;
  logic [4:0] count;

  out_item_t expected_outcomes [$];

  function automatic out_item_t lock_outcome(in_item_t req);
    out_item_t  res;
    logic [3:0] tail;
    res.outcome    = OC_IGNORED;
    res.queue_full = 1'b0;
    res.woken_id   = 8'd0;
    if (req.req_type == REQ_LOCK) begin
      if (count >= SLOTS) begin
        res.queue_full = 1'b1;
      end else begin
        tail = head + count[3:0];
        slots[tail] = req.proc_id;
        count = count + 5'd1;
        if (held) begin
          res.outcome = OC_WAIT;
        end else begin
          owner = req.proc_id;
          held = 1'b1;
          res.outcome = OC_GRANTED;
        end
      end
    end else if (held) begin
      // The owner sits at the head; drop it and pass the lock on if anyone waits.
      if (count > 0) begin
        head = head + 4'd1;
        count = count - 5'd1;
      end
      if (count > 0) begin
        owner = slots[head];
        res.woken_id = owner;
        res.outcome = OC_HANDOVER;
      end else begin
        held = 1'b0;
        owner = 8'd0;
        res.outcome = OC_FREED;
      end
    end
    res.holder_id = owner;
    res.is_locked = held;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp;
    logic      bad;
    if (!rst_n) begin
      held = 1'b0;
      owner = 8'd0;
      head = 4'd0;
      count = 5'd0;
      expected_outcomes.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected result item outcome=%0d owner=%0d",
                     out_item.outcome, out_item.holder_id);
        end else begin
          exp = expected_outcomes.pop_front();
          bad = (out_item.outcome !== exp.outcome) ||
                (out_item.queue_full !== exp.queue_full) ||
                (out_item.woken_id !== exp.woken_id) ||
                (out_item.holder_id !== exp.holder_id) ||
                (out_item.is_locked !== exp.is_locked);
          if (bad) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("ERROR: result mismatch: expected outcome=%0d full=%0d woken=%0d owner=%0d locked=%0d",
                       exp.outcome, exp.queue_full, exp.woken_id, exp.holder_id,
                       exp.is_locked);
              $display("       got outcome=%0d full=%0d woken=%0d owner=%0d locked=%0d",
                       out_item.outcome, out_item.queue_full, out_item.woken_id,
                       out_item.holder_id, out_item.is_locked);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_outcomes.push_back(lock_outcome(in_item));
    end
    outstanding = expected_outcomes.size();
  end

endmodule

// ===== tb/fifo_handoff_mutex_top_tb.sv =====
// Testbench top for the FIFO hand-off mutex: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module fifo_handoff_mutex_top_tb;
  import fhm_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The slowest
  // correct step is a full sender gap, the capture and execute steps and a full receiver
  // stall, well under this.
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 850;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // When set, neither side inserts idle cycles, so back-to-back traffic is covered.
  logic burst = 1'b0;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;
  int stall_left = 0;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  fifo_handoff_mutex_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  fhm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Result side: after each accepted result, ready may drop for a random stall (never
  // in burst stretches) and then stays high until the next one is taken.
  always @(posedge clk) begin
    int s;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      s = burst ? 0 : $urandom_range(0, 7);
      if (s == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= s;
      end
    end else if (!out_ready) begin
      if (stall_left <= 1) begin
        out_ready <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
        $display("** fifo_handoff_mutex_top: FAILED **");
        $finish;
      end
    end
  end

  // Offers one item after a random gap and returns at the edge where it is taken.
  // With no gap, valid simply stays high and the payload changes, so the line is
  // never lowered and raised in the same step.
  task automatic send_request(input logic kind, input logic [7:0] pid);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.req_type <= kind;
    in_item.proc_id <= pid;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int sent;
    int phase_len;
    int lock_pct;
    int pct_choices [5];
    logic kind;
    pct_choices = '{10, 35, 50, 65, 90};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An unlock on a free lock is ignored; an id of zero is granted
    // and shows as owner zero while locked.
    send_request(REQ_UNLOCK, 8'h00);
    send_request(REQ_LOCK, 8'h00);
    send_request(REQ_UNLOCK, 8'hFF);
    // Fill the queue: one owner and fifteen waiters with assorted bit patterns.
    send_request(REQ_LOCK, 8'hFF);
    for (int i = 1; i < 16; i++)
      send_request(REQ_LOCK, 8'(i * 17) ^ 8'h5A);
    // A lock on the full queue is rejected; an unlock hands over; then refill
    // so the tail wraps past the end of the storage and reject once more.
    send_request(REQ_LOCK, 8'h7F);
    send_request(REQ_UNLOCK, 8'h00);
    send_request(REQ_LOCK, 8'h80);
    send_request(REQ_LOCK, 8'h01);

    // Random part in phases. Each phase leans toward locks or unlocks, so the queue
    // repeatedly fills to the reject point and drains to free, wrapping the index.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(30, 80);
      lock_pct = pct_choices[$urandom_range(0, 4)];
      burst <= ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        kind = ($urandom_range(0, 99) < lock_pct) ? REQ_LOCK : REQ_UNLOCK;
        send_request(kind, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    in_valid <= 1'b0;
    burst <= 1'b0;

    // Drain: wait for every predicted result, then a few cycles for strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** fifo_handoff_mutex_top: PASSED **");
    end else begin
      $display("** fifo_handoff_mutex_top: FAILED **");
    end
    $finish;
  end

endmodule
